>>> rtl/picdec_pkg.sv
// ----------------------------------------------------------------------------
// picdec_pkg
// Types, constants and the opcode table of the 14-bit instruction decoder.
// ----------------------------------------------------------------------------
package picdec_pkg;

	localparam int WORD_BITS = 14;
	localparam int OP_COUNT  = 53;

	localparam logic [2:0] NOTE_NONE     = 3'd0;
	localparam logic [2:0] NOTE_SINGLE   = 3'd1;
	localparam logic [2:0] NOTE_NORMAL   = 3'd2;
	localparam logic [2:0] NOTE_REVERSE  = 3'd3;
	localparam logic [2:0] NOTE_FLAG     = 3'd4;
	localparam logic [2:0] NOTE_FLAG2    = 3'd5;
	localparam logic [2:0] NOTE_FLAG_REV = 3'd6;
	localparam logic [2:0] NOTE_INDEX    = 3'd7;

	typedef struct packed {
		logic [10:0] word_address;
		logic [7:0]  low_byte;
		logic [7:0]  high_byte;
	} item_t;

	typedef struct packed {
		logic [10:0] tag_address;
		logic        valid_res;
		logic [5:0]  op_index;
		logic [2:0]  notation;
		logic [10:0] operand_one;
		logic [6:0]  operand_two;
	} result_t;

	typedef struct packed {
		logic [13:0] prefix;
		logic [3:0]  plen;
		logic [3:0]  len1;
		logic [2:0]  len2;
		logic [2:0]  form;
	} op_entry_t;

	localparam op_entry_t OP_TABLE [OP_COUNT] = '{
		'{14'h07,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h3D,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h05,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h37,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h35,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h36,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h03,  4'd7,  4'd7,  3'd0, NOTE_SINGLE},
		'{14'h040, 4'd12, 4'd0,  3'd0, NOTE_NONE},
		'{14'h09,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h03,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h0A,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h04,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h08,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h01,  4'd7,  4'd7,  3'd0, NOTE_SINGLE},
		'{14'h0D,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h0C,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h02,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h3B,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h0E,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h06,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h0B,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h0F,  4'd6,  4'd1,  3'd7, NOTE_FLAG_REV},
		'{14'h4,   4'd4,  4'd3,  3'd7, NOTE_REVERSE},
		'{14'h5,   4'd4,  4'd3,  3'd7, NOTE_REVERSE},
		'{14'h6,   4'd4,  4'd3,  3'd7, NOTE_REVERSE},
		'{14'h7,   4'd4,  4'd3,  3'd7, NOTE_REVERSE},
		'{14'h3E,  4'd6,  4'd8,  3'd0, NOTE_SINGLE},
		'{14'h39,  4'd6,  4'd8,  3'd0, NOTE_SINGLE},
		'{14'h38,  4'd6,  4'd8,  3'd0, NOTE_SINGLE},
		'{14'h001, 4'd9,  4'd5,  3'd0, NOTE_SINGLE},
		'{14'h63,  4'd7,  4'd7,  3'd0, NOTE_SINGLE},
		'{14'h30,  4'd6,  4'd8,  3'd0, NOTE_SINGLE},
		'{14'h3C,  4'd6,  4'd8,  3'd0, NOTE_SINGLE},
		'{14'h3A,  4'd6,  4'd8,  3'd0, NOTE_SINGLE},
		'{14'h19,  4'd5,  4'd9,  3'd0, NOTE_SINGLE},
		'{14'h00B, 4'd14, 4'd0,  3'd0, NOTE_NONE},
		'{14'h4,   4'd3,  4'd11, 3'd0, NOTE_SINGLE},
		'{14'h00A, 4'd14, 4'd0,  3'd0, NOTE_NONE},
		'{14'h5,   4'd3,  4'd11, 3'd0, NOTE_SINGLE},
		'{14'h009, 4'd14, 4'd0,  3'd0, NOTE_NONE},
		'{14'h34,  4'd6,  4'd8,  3'd0, NOTE_SINGLE},
		'{14'h008, 4'd14, 4'd0,  3'd0, NOTE_NONE},
		'{14'h064, 4'd14, 4'd0,  3'd0, NOTE_NONE},
		'{14'h000, 4'd14, 4'd0,  3'd0, NOTE_NONE},
		'{14'h062, 4'd14, 4'd0,  3'd0, NOTE_NONE},
		'{14'h001, 4'd14, 4'd0,  3'd0, NOTE_NONE},
		'{14'h063, 4'd14, 4'd0,  3'd0, NOTE_NONE},
		'{14'h00C, 4'd11, 4'd3,  3'd0, NOTE_SINGLE},
		'{14'h62,  4'd7,  4'd1,  3'd6, NOTE_FLAG},
		'{14'h002, 4'd11, 4'd1,  3'd2, NOTE_FLAG2},
		'{14'h7E,  4'd7,  4'd1,  3'd6, NOTE_INDEX},
		'{14'h003, 4'd11, 4'd1,  3'd2, NOTE_FLAG2},
		'{14'h7F,  4'd7,  4'd1,  3'd6, NOTE_INDEX}
	};

endpackage

>>> rtl/pic_enhanced_midrange_instr_decoder_top.sv
// ----------------------------------------------------------------------------
// pic_enhanced_midrange_instr_decoder_top
// 14-bit instruction decoder: input register, table decode, result register.
// ----------------------------------------------------------------------------
// an accepted beat passes the input register, then the result register, to its result beat
// throughput: one beat per cycle while the output is not stalled; the decode table sits between two registers
// a stalled output holds the result register and, once full, the input register
// reset clears both valid flags; payload registers are not reset
module pic_enhanced_midrange_instr_decoder_top import picdec_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t decoded;
	logic    en_s1;
	logic    en_s2;

	assign en_s2      = !valid_s2 || result_ready;
	assign en_s1      = !valid_s1 || en_s2;
	assign item_ready = en_s1;

	picdec_decode u_decode (
		.item   (item_s1),
		.result (decoded)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= item_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && item_valid) begin
			item_s1 <= item;
		end
		if (en_s2 && valid_s1) begin
			result_s2 <= decoded;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item_ready)
		else $error("input register empty but not ready");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.valid_res |->
		result.op_index == '0 && result.notation == NOTE_NONE &&
		result.operand_one == '0 && result.operand_two == '0)
		else $error("unmatched word carries nonzero fields");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.valid_res |-> result.op_index < 6'(OP_COUNT))
		else $error("op index beyond table");

	a_none_no_operands: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.notation == NOTE_NONE |->
		result.operand_one == '0 && result.operand_two == '0)
		else $error("operand on an operation without operands");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && en_s2 |=> valid_s2)
		else $error("input register beat lost on advance");

endmodule

>>> rtl/picdec_decode.sv
// ----------------------------------------------------------------------------
// picdec_decode
// Prefix match against the opcode table, first hit wins, operand extraction.
// ----------------------------------------------------------------------------
module picdec_decode import picdec_pkg::*; (
	input  item_t   item,
	output result_t result
);

	logic [13:0] word;
	logic [13:0] pick_word [OP_COUNT];
	logic [13:0] pick_one  [OP_COUNT];
	logic [13:0] pick_two  [OP_COUNT];
	logic [OP_COUNT-1:0] hit;
	logic        found;

	assign word = {item.high_byte[5:0], item.low_byte};

	always_comb begin
		for (int i = 0; i < OP_COUNT; i++) begin
			pick_word[i] = word >> (4'(WORD_BITS) - OP_TABLE[i].plen);
			hit[i] = (pick_word[i] == OP_TABLE[i].prefix);
			pick_one[i] = (word >> (4'(WORD_BITS) - OP_TABLE[i].plen - OP_TABLE[i].len1))
				& ((14'd1 << OP_TABLE[i].len1) - 14'd1);
			pick_two[i] = (word >> (4'(WORD_BITS) - OP_TABLE[i].plen - OP_TABLE[i].len1
				- {1'b0, OP_TABLE[i].len2}))
				& ((14'd1 << OP_TABLE[i].len2) - 14'd1);
		end
	end

	always_comb begin
		found = 1'b0;
		result = '0;
		result.tag_address = item.word_address;
		for (int i = 0; i < OP_COUNT; i++) begin
			if (hit[i] && !found) begin
				found = 1'b1;
				result.valid_res   = 1'b1;
				result.op_index    = 6'(i);
				result.notation    = OP_TABLE[i].form;
				result.operand_one = pick_one[i][10:0];
				result.operand_two = pick_two[i][6:0];
			end
		end
	end

endmodule
